FILE: hw/rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg - shared types and constants of the ultrasonic echo ranger
// Phase codes, register indexes, trigger timing and divide-by-58 constants.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

   // Pulse counter width default (range 8 to 32)
   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int COUNT_BITS_MAX     = 32;

   // Field and register widths
   localparam int TICK_BITS = 16;
   localparam int CSR_BITS  = 16;
   localparam int OUT_BITS  = 16;

   // Register indexes
   localparam logic CSR_TIMEOUT_US     = 1'b0;
   localparam logic CSR_ERROR_VALUE_CM = 1'b1;

   // Register reset values
   localparam logic [CSR_BITS-1:0] TIMEOUT_RESET = 16'd30000;
   localparam logic [CSR_BITS-1:0] ERROR_RESET   = 16'd0;

   // Trigger sequence lengths in ticks
   localparam logic [TICK_BITS-1:0] LOW_TICKS  = 16'd2;
   localparam logic [TICK_BITS-1:0] HIGH_TICKS = 16'd10;

   // Distance = width / 58 = (width >> 1) / 29, done as a reciprocal multiply.
   // Widths at or above 58 * 65536 saturate, so the divided value is < 2^21.
   localparam int                 US_PER_CM  = 58;
   localparam int                 HALF_BITS  = 21;
   localparam int                 DIV_SHIFT  = 26;
   localparam int                 RECIP_BITS = 22;
   localparam int                 PROD_BITS  = HALF_BITS + RECIP_BITS;
   localparam logic [31:0]        DIV_SAT    = 32'(US_PER_CM * 65536);
   localparam logic [RECIP_BITS-1:0] DIV_RECIP =
      RECIP_BITS'(((64'd1 << DIV_SHIFT) + 64'd28) / 64'd29);

   // Measurement phase
   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_TRIG_LOW  = 3'd1,
      PH_TRIG_HIGH = 3'd2,
      PH_WAIT_RISE = 3'd3,
      PH_WAIT_FALL = 3'd4
   } uer_phase_type;

   // Flags of one tick, handed from the step logic to the output stage
   typedef struct packed {
      logic trig;     // trigger pin level
      logic busy;     // measurement still running after this tick
      logic done;     // measurement finished on this tick
      logic tmo;      // an edge wait ran out
      logic use_err;  // report the error distance
   } uer_flags_type;

endpackage

`default_nettype wire

FILE: hw/rtl/uer_step.sv
// ----------------------------------------------------------------------------
// uer_step - measurement sequencer of the echo ranger
// Holds the phase, tick and pulse counters and advances them by one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_step
   import uer_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step_en,
   input  wire logic                  start,
   input  wire logic                  echo,
   input  wire logic [CSR_BITS-1:0]   timeout,
   output      uer_flags_type         flags,
   output      logic [COUNT_BITS-1:0] pulse
);

   localparam logic [COUNT_BITS-1:0] PulseMax = {COUNT_BITS{1'b1}};

   uer_phase_type          phase_ff, phase_in, phase_eff;
   logic [TICK_BITS-1:0]   ticks_ff, ticks_in;
   logic [COUNT_BITS-1:0]  pulse_ff, pulse_in;
   logic                   prev_ff, prev_in;
   logic                   pend_ff, pend_in;
   logic                   rise, fall, fail, ok, trig, done;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         ticks_ff <= '0;
         pulse_ff <= '0;
         prev_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         pulse_ff <= pulse_in;
         prev_ff  <= prev_in;
         pend_ff  <= pend_in;
      end
   end

   assign rise = echo & ~prev_ff;
   assign fall = ~echo & prev_ff;

   // Next state for one tick
   always_comb begin
      phase_eff = phase_ff;
      if (phase_ff != PH_TRIG_LOW && phase_ff != PH_TRIG_HIGH &&
          phase_ff != PH_WAIT_RISE && phase_ff != PH_WAIT_FALL) begin
         phase_eff = PH_IDLE;
      end
      phase_in = phase_eff;
      ticks_in = ticks_ff;
      pulse_in = pulse_ff;
      pend_in  = pend_ff;
      trig     = 1'b0;
      fail     = 1'b0;
      ok       = 1'b0;

      // echo width counts on every busy tick once a rise is captured
      if (phase_eff != PH_IDLE && pend_ff && pulse_ff != PulseMax) begin
         pulse_in = pulse_ff + 1'b1;
      end

      case (phase_eff)
         PH_IDLE: begin
            if (start) begin
               phase_in = PH_TRIG_LOW;
               ticks_in = 16'd1;
               pulse_in = '0;
               pend_in  = 1'b0;
            end
         end
         PH_TRIG_LOW: begin
            if (ticks_ff >= LOW_TICKS) begin
               phase_in = PH_TRIG_HIGH;
               ticks_in = 16'd1;
               trig     = 1'b1;
            end else begin
               ticks_in = ticks_ff + 1'b1;
            end
         end
         PH_TRIG_HIGH: begin
            if (ticks_ff >= HIGH_TICKS) begin
               phase_in = PH_WAIT_RISE;
               ticks_in = '0;
            end else begin
               ticks_in = ticks_ff + 1'b1;
               trig     = 1'b1;
            end
         end
         PH_WAIT_RISE: begin
            if (pend_ff || rise) begin
               if (rise) begin
                  pend_in  = 1'b1;
                  pulse_in = '0;
               end
               phase_in = PH_WAIT_FALL;
               ticks_in = '0;
            end else if (ticks_ff >= timeout) begin
               fail = 1'b1;
            end else begin
               ticks_in = ticks_ff + 1'b1;
            end
         end
         PH_WAIT_FALL: begin
            if (fall) begin
               ok = 1'b1;
            end else if (ticks_ff >= timeout) begin
               fail = 1'b1;
            end else begin
               ticks_in = ticks_ff + 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      // early rise during the trigger pulse arms the capture
      if ((phase_in == PH_TRIG_LOW || phase_in == PH_TRIG_HIGH) && rise) begin
         pend_in  = 1'b1;
         pulse_in = '0;
      end

      done = fail | ok;
      if (done) begin
         phase_in = PH_IDLE;
         ticks_in = '0;
         pend_in  = 1'b0;
      end
      prev_in = echo;

      flags.trig    = trig;
      flags.busy    = (phase_in != PH_IDLE);
      flags.done    = done;
      flags.tmo     = fail;
      flags.use_err = fail | (ok & (pulse_in == '0));
   end

   assign pulse = pulse_in;

endmodule

`default_nettype wire

FILE: hw/rtl/uer_div58.sv
// ----------------------------------------------------------------------------
// uer_div58 - width saturation and distance of the echo ranger
// Clamps the pulse count to 16 bits and divides it by 58 by reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_div58
   import uer_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  wire logic [COUNT_BITS-1:0] count,
   output      logic [OUT_BITS-1:0]   width_us,
   output      logic [OUT_BITS-1:0]   dist_cm
);

   logic [COUNT_BITS_MAX-1:0] wide;
   logic [HALF_BITS-1:0]      half;
   logic [PROD_BITS-1:0]      prod;

   assign wide = COUNT_BITS_MAX'(count);

   // width clamps to the field maximum
   assign width_us = (wide > 32'h0000_FFFF) ? 16'hFFFF : wide[OUT_BITS-1:0];

   // (count >> 1) * ceil(2^26 / 29) >> 26, exact below the saturation point
   assign half = wide[HALF_BITS:1];
   assign prod = PROD_BITS'(half) * PROD_BITS'(DIV_RECIP);

   assign dist_cm = (wide >= DIV_SAT) ? 16'hFFFF
                                      : prod[DIV_SHIFT +: OUT_BITS];

endmodule

`default_nettype wire

FILE: hw/rtl/ultrasonic_echo_ranger_core.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_core - trigger/echo ranging for a pulse-echo sensor
// Tick-driven trigger sequencer, echo width counter and distance output.
// ----------------------------------------------------------------------------
// Feed one word per microsecond tick on req_: the start request and the
// sampled echo pin. Each accepted word yields exactly one rsp_ word, with
// the trigger pin level, busy, and on the finishing tick done, timeout flag,
// echo width and distance in cm. One word is taken every cycle unless
// req_stall is high; a word runs through three registers (input, middle,
// output) on its way to rsp_. Stall on rsp_ holds the pipe and
// back-pressures req_ once the internal stages are full. csr_ registers
// (0: timeout in ticks, 1: error distance): the user must write them while idle; not enforced.
`default_nettype none

module ultrasonic_echo_ranger_core
   import uer_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // configuration
   input  wire logic                csr_wr_en,
   input  wire logic                csr_index,
   input  wire logic [CSR_BITS-1:0] csr_wdata,
   // tick words in
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic                req_start_req,
   input  wire logic                req_echo_level,
   // result words out
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic                rsp_trigger_level,
   output      logic                rsp_busy_res,
   output      logic                rsp_done_res,
   output      logic                rsp_timed_out,
   output      logic [OUT_BITS-1:0] rsp_echo_width_us,
   output      logic [OUT_BITS-1:0] rsp_distance_cm
);

   logic [CSR_BITS-1:0]   timeout_ff, error_ff;
   logic                  in_valid_ff, in_start_ff, in_echo_ff;
   logic                  mid_valid_ff;
   uer_flags_type         mid_flags_ff, step_flags;
   logic [COUNT_BITS-1:0] mid_pulse_ff, step_pulse;
   logic                  out_valid_ff;
   uer_flags_type         out_flags_ff;
   logic [OUT_BITS-1:0]   out_width_ff, out_dist_ff;
   logic [OUT_BITS-1:0]   width_in, dist_in, div_width, div_dist;
   logic                  in_ready, mid_ready, out_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         error_ff   <= ERROR_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TIMEOUT_US:     timeout_ff <= csr_wdata;
            CSR_ERROR_VALUE_CM: error_ff   <= csr_wdata;
            default:            timeout_ff <= timeout_ff;
         endcase
      end
   end

   // Stage ready chain
   assign out_ready = ~out_valid_ff | ~rsp_stall;
   assign mid_ready = ~mid_valid_ff | out_ready;
   assign in_ready  = ~in_valid_ff | mid_ready;
   assign req_stall = ~in_ready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         in_start_ff <= req_start_req;
         in_echo_ff  <= req_echo_level;
      end
   end

   // Sequencer: state advances when the word moves to the middle stage
   uer_step #(
      .COUNT_BITS(COUNT_BITS)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (in_valid_ff & mid_ready),
      .start   (in_start_ff),
      .echo    (in_echo_ff),
      .timeout (timeout_ff),
      .flags   (step_flags),
      .pulse   (step_pulse)
   );

   // Middle register
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (mid_ready) begin
         mid_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_ready) begin
         mid_flags_ff <= step_flags;
         mid_pulse_ff <= step_pulse;
      end
   end

   // Width clamp and distance
   uer_div58 #(
      .COUNT_BITS(COUNT_BITS)
   ) u_div58 (
      .count    (mid_pulse_ff),
      .width_us (div_width),
      .dist_cm  (div_dist)
   );

   always_comb begin
      width_in = '0;
      dist_in  = '0;
      if (mid_flags_ff.done) begin
         if (mid_flags_ff.use_err) begin
            dist_in = error_ff;
         end else begin
            width_in = div_width;
            dist_in  = div_dist;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         out_flags_ff <= mid_flags_ff;
         out_width_ff <= width_in;
         out_dist_ff  <= dist_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_trigger_level = out_flags_ff.trig;
   assign rsp_busy_res      = out_flags_ff.busy;
   assign rsp_done_res      = out_flags_ff.done;
   assign rsp_timed_out     = out_flags_ff.tmo;
   assign rsp_echo_width_us = out_width_ff;
   assign rsp_distance_cm   = out_dist_ff;

   // Checks
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("finished measurement still reported busy");

   a_tmo_with_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timed_out |-> rsp_done_res && rsp_echo_width_us == '0)
      else $error("timeout flagged without done or with a width");

   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_echo_width_us == '0 && rsp_distance_cm == '0)
      else $error("result fields set on a tick without done");

   a_trig_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_trigger_level |-> rsp_busy_res && !rsp_done_res)
      else $error("trigger driven outside a running measurement");

endmodule

`default_nettype wire

FILE: dv/ultrasonic_echo_ranger_checker.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_checker - result checker for the echo ranger core
// Watches the csr_, req_ and rsp_ ports, keeps its own model of the trigger
// sequencer and echo width counter, predicts one result word per accepted
// tick word and compares every accepted result word field by field.
// ----------------------------------------------------------------------------

module ultrasonic_echo_ranger_checker
   import uer_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic                csr_index,
   input  wire logic [CSR_BITS-1:0] csr_wdata,
   input  wire logic                req_valid,
   input  wire logic                req_stall,
   input  wire logic                req_start_req,
   input  wire logic                req_echo_level,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_stall,
   input  wire logic                rsp_trigger_level,
   input  wire logic                rsp_busy_res,
   input  wire logic                rsp_done_res,
   input  wire logic                rsp_timed_out,
   input  wire logic [OUT_BITS-1:0] rsp_echo_width_us,
   input  wire logic [OUT_BITS-1:0] rsp_distance_cm,
   output int                       mismatches,
   output int                       words_due,
   output logic                     measuring
);

   localparam int PULSE_BITS = COUNT_BITS_DEFAULT;

   // One predicted result word
   typedef struct packed {
      logic                trig;
      logic                busy;
      logic                done;
      logic                tmo;
      logic [OUT_BITS-1:0] width;
      logic [OUT_BITS-1:0] dist_cm;
   } range_word_type;

   // Sequencer copy and register copies
   uer_phase_type         stage;
   logic [TICK_BITS-1:0]  stage_ticks;
   logic [PULSE_BITS-1:0] echo_count;
   logic                  echo_seen;
   logic                  rise_armed;
   logic [CSR_BITS-1:0]   timeout_ticks;
   logic [CSR_BITS-1:0]   error_cm;

   range_word_type readings_due[$];
   int             words_checked;

   // Advance the sequencer by one tick and return the word it produces
   function automatic range_word_type range_tick(input logic start, input logic echo);
      range_word_type word;
      logic           rise;
      logic           fall;
      logic           fail;
      logic           ok;
      word = '0;
      fail = 1'b0;
      ok   = 1'b0;
      rise = echo && !echo_seen;
      fall = !echo && echo_seen;
      if (stage == PH_IDLE) begin
         if (start) begin
            stage       = PH_TRIG_LOW;
            stage_ticks = TICK_BITS'(1);
            echo_count  = '0;
            rise_armed  = 1'b0;
         end
      end else begin
         // width counts from the captured rise, saturating
         if (rise_armed && echo_count != '1) echo_count++;
         case (stage)
            PH_TRIG_LOW: begin
               if (stage_ticks >= LOW_TICKS) begin
                  stage       = PH_TRIG_HIGH;
                  stage_ticks = TICK_BITS'(1);
                  word.trig   = 1'b1;
               end else begin
                  stage_ticks++;
               end
            end
            PH_TRIG_HIGH: begin
               if (stage_ticks >= HIGH_TICKS) begin
                  stage       = PH_WAIT_RISE;
                  stage_ticks = '0;
               end else begin
                  stage_ticks++;
                  word.trig = 1'b1;
               end
            end
            PH_WAIT_RISE: begin
               if (rise_armed || rise) begin
                  if (rise) begin
                     rise_armed = 1'b1;
                     echo_count = '0;
                  end
                  stage       = PH_WAIT_FALL;
                  stage_ticks = '0;
               end else if (stage_ticks >= timeout_ticks) begin
                  fail = 1'b1;
               end else begin
                  stage_ticks++;
               end
            end
            default: begin
               if (fall) begin
                  ok = 1'b1;
               end else if (stage_ticks >= timeout_ticks) begin
                  fail = 1'b1;
               end else begin
                  stage_ticks++;
               end
            end
         endcase
      end

      // rise seen while the trigger sequence runs: latest one wins
      if ((stage == PH_TRIG_LOW || stage == PH_TRIG_HIGH) && rise) begin
         rise_armed = 1'b1;
         echo_count = '0;
      end

      if (fail) begin
         word.done    = 1'b1;
         word.tmo     = 1'b1;
         word.dist_cm = error_cm;
      end else if (ok) begin
         word.done = 1'b1;
         if (echo_count == '0) begin
            word.dist_cm = error_cm;
         end else begin
            word.width   = (32'(echo_count) > 32'hFFFF) ? '1 : OUT_BITS'(echo_count);
            word.dist_cm = OUT_BITS'(echo_count / US_PER_CM);
         end
      end
      if (word.done) begin
         stage       = PH_IDLE;
         stage_ticks = '0;
         rise_armed  = 1'b0;
      end
      echo_seen = echo;
      word.busy = (stage != PH_IDLE);
      return word;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
   endtask

   task automatic check_field(input string field, input logic [OUT_BITS-1:0] got,
                              input logic [OUT_BITS-1:0] want);
      if (got != want)
         report_mismatch($sformatf("word %0d %s got %0d want %0d",
                                   words_checked, field, got, want));
   endtask

   // Register writes, tick words in, result words out
   always @(posedge clock) begin : watch
      range_word_type want;
      if (reset) begin
         stage         = PH_IDLE;
         stage_ticks   = '0;
         echo_count    = '0;
         echo_seen     = 1'b0;
         rise_armed    = 1'b0;
         timeout_ticks = TIMEOUT_RESET;
         error_cm      = ERROR_RESET;
         readings_due.delete();
         words_checked = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TIMEOUT_US:     timeout_ticks = csr_wdata;
               CSR_ERROR_VALUE_CM: error_cm      = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            readings_due.push_back(range_tick(req_start_req, req_echo_level));
         if (rsp_valid && !rsp_stall) begin
            words_checked++;
            if (readings_due.size() == 0) begin
               report_mismatch($sformatf("word %0d arrived with no tick pending",
                                         words_checked));
            end else begin
               want = readings_due.pop_front();
               check_field("trigger_level", OUT_BITS'(rsp_trigger_level),
                           OUT_BITS'(want.trig));
               check_field("busy", OUT_BITS'(rsp_busy_res), OUT_BITS'(want.busy));
               check_field("done", OUT_BITS'(rsp_done_res), OUT_BITS'(want.done));
               check_field("timed_out", OUT_BITS'(rsp_timed_out), OUT_BITS'(want.tmo));
               check_field("echo_width_us", rsp_echo_width_us, want.width);
               check_field("distance_cm", rsp_distance_cm, want.dist_cm);
            end
         end
      end
      words_due <= readings_due.size();
      measuring <= (stage != PH_IDLE);
   end

endmodule

FILE: dv/ultrasonic_echo_ranger_core_tb.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_core_tb - testbench of the echo ranger core
// Feeds microsecond tick words: directed trigger/echo cases, then random
// measurements under changing timeout and error settings with random gaps
// on req_ and random stall on rsp_.
// ----------------------------------------------------------------------------

module ultrasonic_echo_ranger_core_tb;
   import uer_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_TICKS = 1100;
   localparam int CALM_TICKS   = 200;
   localparam int REGS_EVERY   = 230;
   localparam int NO_PAUSE     = -1_000_000;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                csr_wr_en      = 1'b0;
   logic                csr_index      = CSR_TIMEOUT_US;
   logic [CSR_BITS-1:0] csr_wdata      = '0;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic                req_start_req  = 1'b0;
   logic                req_echo_level = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic                rsp_trigger_level;
   logic                rsp_busy_res;
   logic                rsp_done_res;
   logic                rsp_timed_out;
   logic [OUT_BITS-1:0] rsp_echo_width_us;
   logic [OUT_BITS-1:0] rsp_distance_cm;

   int   mismatches;
   int   words_due;
   logic measuring;

   int   ticks_sent  = 0;
   int   cycle_count = 0;
   int   cur_timeout = int'(TIMEOUT_RESET);
   bit   tx_idle_on  = 1'b0;
   bit   rx_idle_on  = 1'b0;

   ultrasonic_echo_ranger_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_start_req     (req_start_req),
      .req_echo_level    (req_echo_level),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_trigger_level (rsp_trigger_level),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_done_res      (rsp_done_res),
      .rsp_timed_out     (rsp_timed_out),
      .rsp_echo_width_us (rsp_echo_width_us),
      .rsp_distance_cm   (rsp_distance_cm)
   );

   ultrasonic_echo_ranger_checker i_check (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_start_req     (req_start_req),
      .req_echo_level    (req_echo_level),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_trigger_level (rsp_trigger_level),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_done_res      (rsp_done_res),
      .rsp_timed_out     (rsp_timed_out),
      .rsp_echo_width_us (rsp_echo_width_us),
      .rsp_distance_cm   (rsp_distance_cm),
      .mismatches        (mismatches),
      .words_due         (words_due),
      .measuring         (measuring)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ultrasonic_echo_ranger_core_tb NOT OK");
         $finish;
      end
   end

   // Result side: random stall bursts
   initial begin : sink
      int run;
      forever begin
         run = $urandom_range(1, 24);
         rsp_stall <= 1'b0;
         repeat (run) @(posedge clock);
         if (rx_idle_on && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
      end
   end

   // One tick word; valid stays high on return until the next word or a hold
   task automatic put_tick(input logic start, input logic echo);
      if (tx_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_start_req  <= start;
      req_echo_level <= echo;
      do @(posedge clock); while (req_stall);
      ticks_sent++;
   endtask

   // Stop sending and wait for every pending result word
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_due != 0);
      repeat (4) @(posedge clock);
   endtask

   // Drain and run quiet ticks until no measurement is in progress
   task automatic settle();
      drain();
      while (measuring) begin
         repeat (8) put_tick(1'b0, 1'b0);
         drain();
      end
   endtask

   task automatic set_regs(input logic [CSR_BITS-1:0] tmo, input logic [CSR_BITS-1:0] err);
      settle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_TIMEOUT_US;
      csr_wdata <= tmo;
      @(posedge clock);
      csr_index <= CSR_ERROR_VALUE_CM;
      csr_wdata <= err;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_timeout = int'(tmo);
   endtask

   // Bit i of each mask is tick i
   task automatic play(input int n, input logic [63:0] echo_bits, input logic [63:0] start_bits);
      for (int i = 0; i < n; i++) put_tick(start_bits[i], echo_bits[i]);
   endtask

   // Start at tick 0, echo high for ticks rise_at .. rise_at+high-1
   task automatic pulse(input int pre, input int rise_at, input int high, input int total,
                        input int start_odds, input int pause_at);
      logic start;
      for (int i = -pre; i < total; i++) begin
         start = (i == 0) || (i > 0 && start_odds != 0 && $urandom_range(1, start_odds) == 1);
         if (i == pause_at) drain();
         put_tick(start, i >= rise_at && i < rise_at + high);
      end
   endtask

   initial begin : stimulus
      int                  pre;
      int                  rise_at;
      int                  high;
      int                  total;
      int                  cap;
      int                  pause_at;
      int                  next_regs_at;
      logic [CSR_BITS-1:0] tmo;
      logic [CSR_BITS-1:0] err;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;

      // reset settings: rise in the wait, width 60, one pause mid-measurement
      pulse(0, 14, 60, 80, 0, 30);

      set_regs(16'd3, 16'hFFFF);
      // no echo: rise wait runs out
      play(20, 64'h0, 64'h1);
      // two rises during the trigger, the later one sets the width
      play(20, 64'h0000_FF8C, 64'h1);
      // rise on the tick the trigger ends is lost, rise wait runs out
      play(32, 64'h7FFF_F000, 64'h1);
      // fall before the fall wait is ignored, fall wait runs out
      play(20, 64'h38, 64'h1);
      // start while busy and on the done tick ignored, next start taken
      play(40, 64'h1_C000, 64'h6_0021);
      // echo already high at start: no rise seen
      play(24, 64'h1F_FFFF, 64'h4);
      // rise on the start tick itself
      play(20, 64'h7FFF, 64'h1);

      set_regs(16'd0, 16'h1234);
      play(16, 64'h0, 64'h1);
      // one-tick echo: width 1, distance 0
      play(16, 64'h2000, 64'h1);

      // random measurements
      ticks_sent   = 0;
      next_regs_at = 0;
      while (ticks_sent < RANDOM_TICKS) begin
         if (ticks_sent >= next_regs_at) begin
            case ($urandom_range(0, 5))
               0:       tmo = 16'd0;
               1:       tmo = 16'd1;
               2:       tmo = CSR_BITS'($urandom_range(2, 12));
               5:       tmo = CSR_BITS'($urandom_range(150, 400));
               default: tmo = CSR_BITS'($urandom_range(20, 80));
            endcase
            case ($urandom_range(0, 3))
               0:       err = 16'h0;
               1:       err = 16'hFFFF;
               default: err = CSR_BITS'($urandom_range(0, 65535));
            endcase
            set_regs(tmo, err);
            next_regs_at = ticks_sent + REGS_EVERY;
         end

         if (ticks_sent >= RANDOM_TICKS - CALM_TICKS) begin
            tx_idle_on = 1'b0;
            rx_idle_on = 1'b0;
         end else begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
         end

         pre     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
         rise_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) :
                   $urandom_range(13, 13 + ((cur_timeout + 2 > 30) ? 30 : cur_timeout + 2));
         if (pre > 0 && $urandom_range(0, 3) == 0) rise_at = -pre;
         cap     = (cur_timeout + 3 > 200) ? 200 : cur_timeout + 3;
         high    = $urandom_range(0, 1) ? $urandom_range(1, cap) : $urandom_range(58, 200);
         total   = rise_at + high + $urandom_range(1, 4);
         pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : NO_PAUSE;

         case ($urandom_range(0, 9))
            // noise: random echo and start requests
            0: repeat ($urandom_range(10, 40))
                  put_tick($urandom_range(0, 7) == 0, $urandom_range(0, 1) == 1);
            // cut-short measurement
            1: begin
               total = (rise_at + high > 1) ? $urandom_range(1, rise_at + high) : 1;
               pulse(pre, rise_at, high, total, 0, NO_PAUSE);
            end
            default: pulse(pre, rise_at, high, total, $urandom_range(0, 1) ? 0 : 12, pause_at);
         endcase
      end

      drain();
      if (mismatches == 0 && words_due == 0) begin
         $display("ultrasonic_echo_ranger_core_tb OK");
      end else begin
         $display("ultrasonic_echo_ranger_core_tb NOT OK");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/uer_pkg.sv
hw/rtl/uer_step.sv
hw/rtl/uer_div58.sv
hw/rtl/ultrasonic_echo_ranger_core.sv
dv/ultrasonic_echo_ranger_checker.sv
dv/ultrasonic_echo_ranger_core_tb.sv
